// ----- rtl/core/txc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package txc_pkg;

	// One stored cell: attribute in the high byte, character in the low byte.
	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} cell_t;

	// One response as it waits in the output queue.
	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attribute;
		logic [4:0] cursor_row;
		logic [6:0] cursor_column;
	} rsp_t;

	localparam logic       KIND_PUT     = 1'b0;
	localparam logic       KIND_READ    = 1'b1;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] NUL_CODE     = 8'h00;
	localparam logic [7:0] ATTR_RESET   = 8'h0F;

endpackage

`default_nettype wire

// ----- rtl/core/txc_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface txc_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;
	logic [4:0] read_row;
	logic [6:0] read_column;

	modport source (output valid, kind, char_code, read_row, read_column, input ready);
	modport sink (input valid, kind, char_code, read_row, read_column, output ready);
endinterface

interface txc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [7:0] cell_attribute;
	logic [4:0] cursor_row;
	logic [6:0] cursor_column;

	modport source (output valid, cell_char, cell_attribute, cursor_row, cursor_column,
		input ready);
	modport sink (input valid, cell_char, cell_attribute, cursor_row, cursor_column,
		output ready);
endinterface

interface txc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_attribute;

	modport source (output valid, text_attribute, input ready);
	modport sink (input valid, text_attribute, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Responses: a put request pushes its response in the cycle it is accepted, a read
// from ST_READ with the memory data, both through a two-entry response queue.
// Flow: one put per cycle while the response queue has space; a read holds off
// requests in ST_READ; a newline or wrap on the last row blanks one ring row in
// ST_SCROLL. Reset: arst_n clears control state, then a pass in ST_CLEAR zeroes
// the cell memory; requests wait for it, configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  wire        clk,
	input  wire        arst_n,
	txc_req_if.sink    req,
	txc_rsp_if.source  rsp,
	txc_cfg_if.sink    cfg
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS + 1);

	localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0] FULL_COL  = CW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [RW:0]   ROWS_X    = (RW + 1)'(ROWS);

	// The memory is a ring of rows: top_q is the physical row shown as row 0, so a
	// scroll only moves top_q on and blanks the row that falls out at the top.
	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_READ   = 4'b0100,
		ST_SCROLL = 4'b1000
	} state_t;

	state_t         state_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  top_q;
	logic [7:0]     attr_q;
	logic [AW-1:0]  sweep_q;
	logic [CW-1:0]  scr_col_q;
	logic [AW-1:0]  scr_base_q;
	logic           char_pend_q;
	logic [7:0]     char_q;
	logic           rd_hit_q;

	logic           accept;
	logic           is_read;
	logic           is_newline;
	logic           adv;
	logic           last_row;
	logic           do_scroll;
	logic [RW-1:0]  row_n;
	logic [CW-1:0]  col_base;
	logic [CW-1:0]  col_n;
	logic [RW-1:0]  top_n;
	logic           rd_hit;
	logic [RW-1:0]  addr_row;
	logic [CW-1:0]  addr_col;
	logic [RW:0]    phys_sum;
	logic [RW-1:0]  phys_row;
	logic [AW-1:0]  addr_c;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	txc_pkg::cell_t mem_wdata;
	logic           mem_re;
	txc_pkg::cell_t mem_rdata;

	logic           q_space;
	logic           q_push;
	txc_pkg::rsp_t  q_data;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE) && q_space;
	assign cfg.ready  = 1'b1;
	assign is_read    = (req.kind == txc_pkg::KIND_READ);
	assign is_newline = (req.char_code == txc_pkg::NEWLINE_CODE);

	// A newline always moves down; any other character moves down first when the
	// row is full. Moving down from the last row scrolls instead.
	assign adv       = is_newline || (col_q == FULL_COL);
	assign last_row  = (row_q == LAST_ROW);
	assign do_scroll = adv && last_row;
	assign row_n     = (adv && !last_row) ? row_q + RW'(1) : row_q;
	assign col_base  = adv ? '0 : col_q;
	assign col_n     = is_newline ? '0 : col_base + CW'(1);
	assign top_n     = do_scroll ? ((top_q == LAST_ROW) ? '0 : top_q + RW'(1)) : top_q;

	// Reads outside the screen return a zero cell and leave the memory alone.
	assign rd_hit = (32'(req.read_row) < ROWS) && (32'(req.read_column) < COLUMNS);

	// One address path serves the read, the direct write and the base of the row
	// to blank; for a scroll that row is the old top, shown as row 0 before it.
	always_comb begin
		if (is_read) begin
			addr_row = RW'(req.read_row);
			addr_col = CW'(req.read_column);
		end else if (do_scroll) begin
			addr_row = '0;
			addr_col = '0;
		end else begin
			addr_row = row_n;
			addr_col = col_base;
		end
		phys_sum = {1'b0, addr_row} + {1'b0, top_q};
		if (phys_sum >= ROWS_X) begin
			phys_sum = phys_sum - ROWS_X;
		end
		phys_row = phys_sum[RW-1:0];
		addr_c   = AW'(phys_row) * COLS_A + AW'(addr_col);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_c;
		mem_wdata = '{attr: attr_q, chr: req.char_code};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_we = accept && !is_read && !is_newline && !do_scroll;
			end
			ST_SCROLL: begin
				// The first column of the new bottom row takes the character that
				// caused a wrap; every other column is blanked.
				mem_we    = 1'b1;
				mem_waddr = scr_base_q + AW'(scr_col_q);
				mem_wdata.chr = (scr_col_q == '0 && char_pend_q) ? char_q
					: txc_pkg::BLANK_CODE;
			end
			ST_READ: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re = accept && is_read && rd_hit;

	txc_store #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr_c),
		.rdata(mem_rdata)
	);

	// A put answers at once with the new cursor; a read answers in the cycle after
	// it is accepted, from ST_READ, when the memory data arrives.
	always_comb begin
		q_push = 1'b0;
		q_data = '{cell_char: txc_pkg::NUL_CODE, cell_attribute: txc_pkg::NUL_CODE,
			cursor_row: 5'(row_q), cursor_column: 7'(col_q)};
		if (state_q == ST_READ) begin
			q_push = 1'b1;
			if (rd_hit_q) begin
				q_data.cell_char      = mem_rdata.chr;
				q_data.cell_attribute = mem_rdata.attr;
			end
		end else if (accept && !is_read) begin
			q_push               = 1'b1;
			q_data.cursor_row    = 5'(row_n);
			q_data.cursor_column = 7'(col_n);
		end
	end

	txc_rspq u_rspq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.space    (q_space),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			top_q       <= '0;
			attr_q      <= txc_pkg::ATTR_RESET;
			sweep_q     <= '0;
			scr_col_q   <= '0;
			char_pend_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				attr_q <= cfg.text_attribute;
			end
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (is_read) begin
							state_q <= ST_READ;
						end else begin
							row_q       <= row_n;
							col_q       <= col_n;
							top_q       <= top_n;
							scr_col_q   <= '0;
							char_pend_q <= !is_newline;
							if (do_scroll) begin
								state_q <= ST_SCROLL;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					scr_col_q <= scr_col_q + CW'(1);
					if (scr_col_q == LAST_COL) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q     <= req.char_code;
			rd_hit_q   <= rd_hit;
			scr_base_q <= addr_c;
		end
	end

	// The cursor stays on the screen: row below ROWS, column at most COLUMNS.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < ROWS) && (32'(col_q) <= COLUMNS))
		else $error("cursor left the screen");

	// The response queue never takes a push it has no room for.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_space || (rsp.valid && rsp.ready)))
		else $error("response queue overflow");

	// An accepted read is answered from the memory in the following cycle.
	a_read_next: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_read) |=> (state_q == ST_READ) && q_push)
		else $error("read response not produced");

	// No request is taken while memory sweeps are running.
	a_sweep_block: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) || (state_q == ST_SCROLL)) |-> !req.ready)
		else $error("request taken during a sweep");

endmodule

`default_nettype wire

// ----- rtl/core/txc_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Cell memory: one write port, one read port with registered data.
module txc_store #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire               clk,
	input  wire               we,
	input  wire [AW-1:0]      waddr,
	input  txc_pkg::cell_t    wdata,
	input  wire               re,
	input  wire [AW-1:0]      raddr,
	output txc_pkg::cell_t    rdata
);

	txc_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/txc_rspq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-entry response queue; lets a request in while a response still waits.
module txc_rspq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  txc_pkg::rsp_t   push_data,
	output logic            space,
	txc_rsp_if.source       rsp
);

	localparam logic [1:0] FULL = 2'd2;

	txc_pkg::rsp_t head_q;
	txc_pkg::rsp_t tail_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop   = rsp.valid && rsp.ready;
	assign space = (cnt_q != FULL);

	assign rsp.valid          = (cnt_q != 2'd0);
	assign rsp.cell_char      = head_q.cell_char;
	assign rsp.cell_attribute = head_q.cell_attribute;
	assign rsp.cursor_row     = head_q.cursor_row;
	assign rsp.cursor_column  = head_q.cursor_column;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == FULL) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push && cnt_q == 2'd0) begin
			head_q <= push_data;
		end
		if (push && ((cnt_q == 2'd1 && !pop) || (cnt_q == FULL && pop))) begin
			tail_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- dv/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_tb;

	localparam int ROWS             = 25;
	localparam int COLUMNS          = 80;
	localparam int HALF_PERIOD      = 6;
	localparam int LIMIT_CYCLES     = 1000000;
	localparam int HOLD_OFF_CYCLES  = 400;
	localparam int PHASE_ITEMS      = 340;
	localparam int PHASE_COUNT      = 5;
	// A scroll blanks one row, so the longest quiet stretch inside the block is a row's blanking.
	localparam int SETTLE_CYCLES    = COLUMNS + 20;

	// Shadow copy of the console: the cell store, the cursor and the attribute
	// register, plus the responses that the accepted requests are owed.
	class console_scoreboard #(int ROW_COUNT = ROWS, int COLUMN_COUNT = COLUMNS);
		txc_pkg::cell_t screen [ROW_COUNT * COLUMN_COUNT];
		int unsigned    row_pos;
		int unsigned    col_pos;
		logic [7:0]     attribute;
		txc_pkg::rsp_t  awaited [$];
		int unsigned    mismatches;

		function new();
			foreach (screen[i]) screen[i] = '0;
			row_pos    = 0;
			col_pos    = 0;
			attribute  = txc_pkg::ATTR_RESET;
			mismatches = 0;
		endfunction

		function void set_attribute(logic [7:0] value);
			attribute = value;
		endfunction

		function void scroll_up();
			txc_pkg::cell_t blank;
			blank.attr = attribute;
			blank.chr  = txc_pkg::BLANK_CODE;
			for (int i = 0; i + COLUMN_COUNT < ROW_COUNT * COLUMN_COUNT; i++) begin
				screen[i] = screen[i + COLUMN_COUNT];
			end
			for (int i = (ROW_COUNT - 1) * COLUMN_COUNT; i < ROW_COUNT * COLUMN_COUNT; i++) begin
				screen[i] = blank;
			end
		endfunction

		function void next_row();
			col_pos = 0;
			if (row_pos + 1 >= ROW_COUNT) begin
				row_pos = ROW_COUNT - 1;
				scroll_up();
			end else begin
				row_pos++;
			end
		endfunction

		function void note_request(logic kind, logic [7:0] code, logic [4:0] rrow,
				logic [6:0] rcol);
			txc_pkg::rsp_t  outcome;
			txc_pkg::cell_t stored;
			outcome = '0;
			if (kind == txc_pkg::KIND_PUT) begin
				if (code == txc_pkg::NEWLINE_CODE) begin
					next_row();
				end else begin
					if (col_pos >= COLUMN_COUNT) next_row();
					screen[row_pos * COLUMN_COUNT + col_pos].attr = attribute;
					screen[row_pos * COLUMN_COUNT + col_pos].chr  = code;
					col_pos++;
				end
			end else if (rrow < ROW_COUNT && rcol < COLUMN_COUNT) begin
				stored = screen[rrow * COLUMN_COUNT + rcol];
				outcome.cell_char      = stored.chr;
				outcome.cell_attribute = stored.attr;
			end
			outcome.cursor_row    = 5'(row_pos);
			outcome.cursor_column = 7'(col_pos);
			awaited.push_back(outcome);
		endfunction

		task report_mismatch(string what, int unsigned wanted, int unsigned seen);
			$display("t=%0t %s: expected %0d, got %0d", $time, what, wanted, seen);
			mismatches++;
		endtask

		task check_response(txc_pkg::rsp_t seen);
			txc_pkg::rsp_t due;
			if (awaited.size() == 0) begin
				report_mismatch("response with no request outstanding, cursor_column",
					0, seen.cursor_column);
				return;
			end
			due = awaited.pop_front();
			if (seen.cell_char !== due.cell_char)
				report_mismatch("cell_char", due.cell_char, seen.cell_char);
			if (seen.cell_attribute !== due.cell_attribute)
				report_mismatch("cell_attribute", due.cell_attribute, seen.cell_attribute);
			if (seen.cursor_row !== due.cursor_row)
				report_mismatch("cursor_row", due.cursor_row, seen.cursor_row);
			if (seen.cursor_column !== due.cursor_column)
				report_mismatch("cursor_column", due.cursor_column, seen.cursor_column);
		endtask

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	txc_req_if req_ch ();
	txc_rsp_if rsp_ch ();
	txc_cfg_if cfg_ch ();

	text_console_writer #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	console_scoreboard console_model = new();

	int unsigned items_sent;
	int unsigned cycle_count;
	bit          gaps_off;
	bit          hold_off_armed;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// All handshakes are observed here, at the rising edge, so that the shadow
	// model sees requests, responses and register writes in the order the block
	// took them. The request is noted before the response is checked: a put
	// answers from a registered queue, so nothing is lost by that order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				console_model.set_attribute(cfg_ch.text_attribute);
			if (req_ch.valid && req_ch.ready)
				console_model.note_request(req_ch.kind, req_ch.char_code,
					req_ch.read_row, req_ch.read_column);
			if (rsp_ch.valid && rsp_ch.ready)
				console_model.check_response('{rsp_ch.cell_char, rsp_ch.cell_attribute,
					rsp_ch.cursor_row, rsp_ch.cursor_column});
		end
	end

	// Watchdog: a hung block must not hang the regression.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("t=%0t timeout after %0d cycles, %0d responses outstanding",
					$time, cycle_count, console_model.pending());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Mostly short idle spells, with the odd long one.
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// Any byte but the newline, so that text runs are as long as intended.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == txc_pkg::NEWLINE_CODE) b = ~txc_pkg::NEWLINE_CODE;
		return b;
	endfunction

	// The response side. It stalls at random, and when the stimulus arms a
	// hold-off it keeps ready low until that hold-off runs out, so that the
	// response queue fills and the block has to push back on requests.
	initial begin : response_side
		int unsigned stall_left;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_armed) begin
				hold_off_armed = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0 && !gaps_off && $urandom_range(0, 99) < 20) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// All driving tasks are entered and left just after a falling edge. On
	// return the request that was taken is still on the bus with valid high;
	// the next request either replaces it straight away, or valid is dropped by
	// send_request() or idle_requests() before any waiting is done.
	task automatic idle_requests();
		req_ch.valid = 1'b0;
	endtask

	task automatic send_request(input logic kind, input logic [7:0] code,
			input logic [4:0] rrow, input logic [6:0] rcol);
		int unsigned gap;
		gap = 0;
		if (!gaps_off && $urandom_range(0, 99) < 25) gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.kind        = kind;
		req_ch.char_code   = code;
		req_ch.read_row    = rrow;
		req_ch.read_column = rcol;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Puts carry random read coordinates and reads a random character: the
	// block must ignore the fields that do not belong to the request kind.
	task automatic put_char(input logic [7:0] code);
		send_request(txc_pkg::KIND_PUT, code, 5'($urandom_range(0, 31)),
			7'($urandom_range(0, 127)));
	endtask

	task automatic read_cell(input logic [4:0] rrow, input logic [6:0] rcol);
		send_request(txc_pkg::KIND_READ, 8'($urandom_range(0, 255)), rrow, rcol);
	endtask

	// Most reads land inside the screen; some use the full field width and
	// so may fall outside it.
	task automatic read_random_cell();
		if ($urandom_range(0, 99) < 85)
			read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
		else
			read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
	endtask

	task automatic write_attribute(input logic [7:0] value);
		cfg_ch.valid          = 1'b1;
		cfg_ch.text_attribute = value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Register writes only go in once the block has answered everything and
	// has had time to finish any scroll.
	task automatic settle();
		idle_requests();
		while (console_model.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random traffic built from text-shaped sequences: short lines ended by a
	// newline, lines filled exactly to the last column and then ended (the
	// newline lands on a full row), overlong lines that wrap, bursts of reads,
	// and single requests with every field random. Frequent newlines and wraps
	// carry the cursor down to the last row, where they scroll.
	task automatic random_phase(input int unsigned budget, input bit drain_mid);
		int unsigned first;
		int unsigned pick;
		int unsigned count;
		bit          drained;
		first   = items_sent;
		drained = 1'b0;
		while (items_sent - first < budget) begin
			if (drain_mid && !drained && items_sent - first >= budget / 2) begin
				// The sender pauses here until every response has come back.
				idle_requests();
				while (console_model.pending() != 0) @(negedge clk);
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				count = $urandom_range(0, 20);
				repeat (count) put_char(text_byte());
				put_char(txc_pkg::NEWLINE_CODE);
			end else if (pick < 75) begin
				count = $urandom_range(1, 4);
				repeat (count) read_random_cell();
			end else if (pick < 83) begin
				count = COLUMNS - console_model.col_pos;
				repeat (count) put_char(text_byte());
				put_char(txc_pkg::NEWLINE_CODE);
			end else if (pick < 88) begin
				count = COLUMNS - console_model.col_pos + $urandom_range(1, 12);
				repeat (count) put_char(text_byte());
			end else begin
				send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] phase_attr;
		arst_n                = 1'b0;
		items_sent            = 0;
		gaps_off              = 1'b0;
		hold_off_armed        = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.kind           = txc_pkg::KIND_PUT;
		req_ch.char_code      = txc_pkg::NUL_CODE;
		req_ch.read_row       = '0;
		req_ch.read_column    = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.text_attribute = txc_pkg::ATTR_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed opening, under the reset attribute. The first requests wait
		// for the clearing pass through ready alone. A zero byte is stored like
		// any other character; the reads then check both byte extremes, a
		// cell never written, the bottom-right corner, and cells beyond the
		// last row and the last column, which must read as zero.
		put_char(txc_pkg::NUL_CODE);
		put_char(8'hFF);
		put_char(8'h41);
		put_char(txc_pkg::NEWLINE_CODE);
		put_char(8'hAA);
		put_char(8'h55);
		put_char(txc_pkg::NEWLINE_CODE);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd1);
		read_cell(5'd0, 7'd2);
		read_cell(5'd0, 7'd3);
		read_cell(5'd1, 7'd0);
		read_cell(5'd1, 7'd1);
		read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
		read_cell(5'(ROWS), 7'd0);
		read_cell(5'd0, 7'(COLUMNS));
		read_cell(5'd31, 7'd127);
		read_cell(5'(ROWS - 1), 7'd127);
		read_cell(5'd31, 7'd0);

		// Each random phase runs under its own attribute, the extremes among
		// them. Phase one opens with a long response hold-off, phase two has
		// the sender wait for a full drain half way, and phase three runs with
		// no idling on either side.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			settle();
			case (phase)
				0:       phase_attr = 8'h00;
				1:       phase_attr = 8'hFF;
				4:       phase_attr = 8'h1E;
				default: phase_attr = 8'($urandom_range(0, 255));
			endcase
			write_attribute(phase_attr);
			gaps_off = (phase == 3);
			if (phase == 1) hold_off_armed = 1'b1;
			random_phase(PHASE_ITEMS, phase == 2);
		end
		gaps_off = 1'b0;

		// Wind down: wait for the last response, then give the block time to
		// show anything spurious.
		idle_requests();
		while (console_model.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (console_model.pending() != 0)
			console_model.report_mismatch("responses outstanding at the end", 0,
				console_model.pending());

		if (console_model.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
